### hdl/cddc_pkg.sv
package cddc_pkg;

  localparam int unsigned LAST_YEAR_DEF = 9999;

  // Register stages from the accept edge to the result register.
  localparam int unsigned NUM_STAGES = 10;

  localparam logic [22:0] EPOCH_SHIFT = 23'd719468;
  localparam logic [17:0] ERA_DAYS    = 18'd146097;

  // Reciprocals for constant division: floor for the era estimate (corrected
  // by one compare later), ceiling for the exact quotients.
  localparam int unsigned ERA_SHIFT  = 32;
  localparam logic [14:0] ERA_RECIP  = 15'((64'd1 << ERA_SHIFT) / 64'd146097);
  localparam int unsigned R1460_SHIFT = 29;
  localparam logic [18:0] R1460      = 19'(((64'd1 << R1460_SHIFT) + 64'd1459) / 64'd1460);
  localparam int unsigned R365_SHIFT = 27;
  localparam logic [18:0] R365       = 19'(((64'd1 << R365_SHIFT) + 64'd364) / 64'd365);
  localparam int unsigned R7_SHIFT   = 26;
  localparam logic [23:0] R7         = 24'(((64'd1 << R7_SHIFT) + 64'd6) / 64'd7);
  localparam int unsigned R25_SHIFT  = 19;
  localparam logic [14:0] R25        = 15'(((64'd1 << R25_SHIFT) + 64'd24) / 64'd25);

  // First day-of-year of each month in a year that starts in March.
  function automatic logic [8:0] month_start(logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] n;
    case (m)
      4'd2:                                  n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:               n = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
      4'd12:                                 n = 5'd31;
      default:                               n = 5'd0;
    endcase
    return n;
  endfunction

  // Divisible by 4, and either not by 25 or also by 16.
  function automatic logic leap_of(logic [13:0] y);
    logic [28:0] prod;
    logic [9:0]  q;
    logic [13:0] r25;
    prod = 29'(y) * 29'(R25);
    q    = prod[28:R25_SHIFT];
    r25  = y - 14'(14'(q) * 14'd25);
    return (y[1:0] == 2'b00) && ((r25 != 14'd0) || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [2:0] mod7(logic [22:0] x);
    logic [46:0] prod;
    logic [20:0] q;
    logic [22:0] r;
    prod = 47'(x) * 47'(R7);
    q    = prod[46:R7_SHIFT];
    r    = x - 23'(23'(q) * 23'd7);
    return r[2:0];
  endfunction

  // floor(yoe / 100) for yoe below 400.
  function automatic logic [1:0] yoe_div100(logic [8:0] yoe);
    logic [12:0] p;
    p = 13'(yoe[8:2]) * 13'd41;
    return p[11:10];
  endfunction

  // Day count of December 31 of year yr; elaboration only.
  function automatic logic [31:0] last_count(int unsigned yr);
    int unsigned era;
    int unsigned yoe;
    int unsigned doe;
    era = yr / 400;
    yoe = yr - era * 400;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + 305;
    return 32'(era * 146097 + doe - 719468);
  endfunction

endpackage

### hdl/civil_date_day_converter_top.sv
// Channel   Handshake              Payload
// input     start / busy           in_mode, in_year_in, in_month_in, in_day_in, in_day_count_in
// result    out_valid (strobe)     out_day_count_out .. out_input_error
//
// One transaction per cycle; busy stays low. Each result comes out of the
// ten-stage pipeline of constant-reciprocal multipliers and compares (era
// split, year-of-era, month search, weekday). Reset (rst_n, synchronous)
// clears the stage valid bits and the strobe. The receiver cannot stall, so
// the pipeline advances every cycle.
module civil_date_day_converter_top #(
  parameter int unsigned LAST_YEAR = cddc_pkg::LAST_YEAR_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [13:0] in_year_in,
  input  logic [3:0]  in_month_in,
  input  logic [4:0]  in_day_in,
  input  logic [21:0] in_day_count_in,
  output logic        out_valid,
  output logic [21:0] out_day_count_out,
  output logic [13:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [2:0]  out_weekday,
  output logic        out_leap_year,
  output logic [4:0]  out_month_length,
  output logic        out_input_error
);

  localparam int unsigned LAST_ST     = cddc_pkg::NUM_STAGES - 1;
  localparam logic [16:0] LAST_YEAR_W = 17'(LAST_YEAR);
  localparam logic [31:0] LAST_COUNT  = cddc_pkg::last_count(LAST_YEAR);

  // The day count keeps one bit above the output width so the weekday comes
  // from the full count when a raised last year pushes it past 22 bits.
  typedef struct packed {
    logic        mode;
    logic        err;
    logic [22:0] z;
    logic [22:0] zz;
    logic [13:0] y;
    logic [13:0] yy;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [3:0]  mp;
    logic [5:0]  era;
    logic [8:0]  yoe;
    logic [1:0]  q100;
    logic [17:0] doe;
    logic [8:0]  doy;
    logic [17:0] tmp;
  } stage_t;

  stage_t            st_r   [1:LAST_ST];
  stage_t            st_nxt [1:LAST_ST];
  logic [LAST_ST:1]  vld_r;
  logic [LAST_ST:1]  vld_nxt;

  logic        out_valid_r;
  logic [21:0] day_count_r, day_count_nxt;
  logic [13:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [2:0]  weekday_r, weekday_nxt;
  logic        leap_r, leap_nxt;
  logic [4:0]  mlen_r, mlen_nxt;
  logic        err_r, err_nxt;

  assign busy = 1'b0;

  if (LAST_ST > 1) begin : g_vld_shift
    assign vld_nxt = {vld_r[LAST_ST-1:1], start & ~busy};
  end else begin : g_vld_one
    assign vld_nxt = start & ~busy;
  end

  // Stage 1: capture, range check, month index or shifted count.
  always_comb begin
    logic       lp;
    logic [4:0] len;
    lp  = cddc_pkg::leap_of(in_year_in);
    len = cddc_pkg::month_len(in_month_in, lp);
    st_nxt[1]      = '0;
    st_nxt[1].mode = in_mode;
    st_nxt[1].y    = in_year_in;
    st_nxt[1].m    = in_month_in;
    st_nxt[1].d    = in_day_in;
    st_nxt[1].z    = {1'b0, in_day_count_in};
    if (!in_mode) begin
      st_nxt[1].err = ({3'b000, in_year_in} < 17'd1970) ||
                      ({3'b000, in_year_in} > LAST_YEAR_W) ||
                      (in_day_in == 5'd0) || (in_day_in > len);
      st_nxt[1].mp  = (in_month_in > 4'd2) ? in_month_in - 4'd3 : in_month_in + 4'd9;
    end else begin
      st_nxt[1].err = {10'b0, in_day_count_in} > LAST_COUNT;
      st_nxt[1].zz  = {1'b0, in_day_count_in} + cddc_pkg::EPOCH_SHIFT;
    end
  end

  // Stage 2: era estimate.
  always_comb begin
    logic [37:0] p_era;
    logic [15:0] p_yy;
    logic [13:0] yy;
    st_nxt[2] = st_r[1];
    p_era = 38'(st_r[1].zz) * 38'(cddc_pkg::ERA_RECIP);
    yy    = st_r[1].y - {13'b0, (st_r[1].m <= 4'd2)};
    p_yy  = 16'(yy[13:4]) * 16'd41;
    if (st_r[1].mode) begin
      st_nxt[2].era = p_era[37:cddc_pkg::ERA_SHIFT];
    end else begin
      st_nxt[2].yy  = yy;
      st_nxt[2].era = p_yy[15:10];
    end
  end

  // Stage 3: remainder inside the era.
  always_comb begin
    st_nxt[3] = st_r[2];
    if (st_r[2].mode) begin
      st_nxt[3].zz = st_r[2].zz - 23'(23'(st_r[2].era) * 23'(cddc_pkg::ERA_DAYS));
    end else begin
      st_nxt[3].yoe = 9'(st_r[2].yy - 14'(14'(st_r[2].era) * 14'd400));
    end
  end

  // Stage 4: correct the era estimate by one; day of year from the month table.
  always_comb begin
    st_nxt[4] = st_r[3];
    if (st_r[3].mode) begin
      if (st_r[3].zz >= 23'(cddc_pkg::ERA_DAYS)) begin
        st_nxt[4].era = st_r[3].era + 6'd1;
        st_nxt[4].doe = 18'(st_r[3].zz - 23'(cddc_pkg::ERA_DAYS));
      end else begin
        st_nxt[4].doe = 18'(st_r[3].zz);
      end
    end else begin
      st_nxt[4].q100 = cddc_pkg::yoe_div100(st_r[3].yoe);
      st_nxt[4].doy  = cddc_pkg::month_start(st_r[3].mp) + 9'(st_r[3].d) - 9'd1;
    end
  end

  // Stage 5: strip leap days from day-of-era, or build day-of-era.
  always_comb begin
    logic [36:0] p1460;
    logic [6:0]  q1460;
    logic [2:0]  q36524;
    logic        q146096;
    st_nxt[5] = st_r[4];
    p1460   = 37'(st_r[4].doe) * 37'(cddc_pkg::R1460);
    q1460   = p1460[35:cddc_pkg::R1460_SHIFT];
    q36524  = 3'(st_r[4].doe >= 18'd36524) + 3'(st_r[4].doe >= 18'd73048) +
              3'(st_r[4].doe >= 18'd109572) + 3'(st_r[4].doe >= 18'd146096);
    q146096 = st_r[4].doe == 18'd146096;
    if (st_r[4].mode) begin
      st_nxt[5].tmp = st_r[4].doe - 18'(q1460) + 18'(q36524) - 18'(q146096);
    end else begin
      st_nxt[5].doe = 18'(18'(st_r[4].yoe) * 18'd365) + 18'(st_r[4].yoe[8:2]) -
                      18'(st_r[4].q100) + 18'(st_r[4].doy);
    end
  end

  // Stage 6: year of era, or the final day count.
  always_comb begin
    logic [36:0] p365;
    logic [22:0] zsum;
    st_nxt[6] = st_r[5];
    p365 = 37'(st_r[5].tmp) * 37'(cddc_pkg::R365);
    zsum = 23'(23'(st_r[5].era) * 23'(cddc_pkg::ERA_DAYS)) + 23'(st_r[5].doe) -
           cddc_pkg::EPOCH_SHIFT;
    if (st_r[5].mode) begin
      st_nxt[6].yoe = p365[35:cddc_pkg::R365_SHIFT];
    end else begin
      st_nxt[6].z = zsum;
    end
  end

  // Stage 7: day of year and base year.
  always_comb begin
    logic [1:0]  q100;
    logic [17:0] yrs;
    st_nxt[7] = st_r[6];
    q100 = cddc_pkg::yoe_div100(st_r[6].yoe);
    yrs  = 18'(18'(st_r[6].yoe) * 18'd365) + 18'(st_r[6].yoe[8:2]) - 18'(q100);
    if (st_r[6].mode) begin
      st_nxt[7].doy = 9'(st_r[6].doe - yrs);
      st_nxt[7].yy  = 14'(14'(st_r[6].era) * 14'd400) + 14'(st_r[6].yoe);
    end
  end

  // Stage 8: month search over the table.
  always_comb begin
    logic [3:0] cnt;
    st_nxt[8] = st_r[7];
    cnt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (st_r[7].doy >= cddc_pkg::month_start(4'(k))) cnt = cnt + 4'd1;
    end
    if (st_r[7].mode) st_nxt[8].mp = cnt;
  end

  // Stage 9: day, month and year from the March-based index.
  always_comb begin
    logic [3:0] mm;
    st_nxt[9] = st_r[8];
    mm = (st_r[8].mp < 4'd10) ? st_r[8].mp + 4'd3 : st_r[8].mp - 4'd9;
    if (st_r[8].mode) begin
      st_nxt[9].m = mm;
      st_nxt[9].d = 5'(st_r[8].doy - cddc_pkg::month_start(st_r[8].mp) + 9'd1);
      st_nxt[9].y = st_r[8].yy + {13'b0, (mm <= 4'd2)};
    end
  end

  // Result register: weekday, leap flag, month length; zero the fields on error.
  always_comb begin
    logic lp;
    lp = cddc_pkg::leap_of(st_r[LAST_ST].y);
    if (st_r[LAST_ST].err) begin
      day_count_nxt = '0;
      year_nxt      = '0;
      month_nxt     = '0;
      day_nxt       = '0;
      weekday_nxt   = '0;
      leap_nxt      = 1'b0;
      mlen_nxt      = '0;
      err_nxt       = 1'b1;
    end else begin
      day_count_nxt = st_r[LAST_ST].z[21:0];
      year_nxt      = st_r[LAST_ST].y;
      month_nxt     = st_r[LAST_ST].m;
      day_nxt       = st_r[LAST_ST].d;
      weekday_nxt   = cddc_pkg::mod7(st_r[LAST_ST].z + 23'd4);
      leap_nxt      = lp;
      mlen_nxt      = cddc_pkg::month_len(st_r[LAST_ST].m, lp);
      err_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[LAST_ST];
    end
  end

  always_ff @(posedge clk) begin
    st_r        <= st_nxt;
    day_count_r <= day_count_nxt;
    year_r      <= year_nxt;
    month_r     <= month_nxt;
    day_r       <= day_nxt;
    weekday_r   <= weekday_nxt;
    leap_r      <= leap_nxt;
    mlen_r      <= mlen_nxt;
    err_r       <= err_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_day_count_out = day_count_r;
  assign out_year_out      = year_r;
  assign out_month_out     = month_r;
  assign out_day_out       = day_r;
  assign out_weekday       = weekday_r;
  assign out_leap_year     = leap_r;
  assign out_month_length  = mlen_r;
  assign out_input_error   = err_r;

endmodule

### hdl/cddc_checker.sv
module cddc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [21:0] out_day_count_out,
  input logic [13:0] out_year_out,
  input logic [3:0]  out_month_out,
  input logic [4:0]  out_day_out,
  input logic [2:0]  out_weekday,
  input logic        out_leap_year,
  input logic [4:0]  out_month_length,
  input logic        out_input_error
);

  // Every accepted transaction yields its result a fixed number of cycles later.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(cddc_pkg::NUM_STAGES) out_valid)
    else $error("result missing after accepted transaction");

  // No result without a transaction accepted at the matching edge.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##(cddc_pkg::NUM_STAGES) !out_valid)
    else $error("result strobe without accepted transaction");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_input_error) |->
      (out_day_count_out == 22'd0 && out_year_out == 14'd0 && out_month_out == 4'd0 &&
       out_day_out == 5'd0 && out_weekday == 3'd0 && !out_leap_year &&
       out_month_length == 5'd0))
    else $error("error result carries nonzero fields");

  a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_input_error) |->
      (out_month_out >= 4'd1 && out_month_out <= 4'd12 && out_day_out >= 5'd1 &&
       out_day_out <= out_month_length && out_month_length >= 5'd28 &&
       out_weekday <= 3'd6))
    else $error("result date out of range");

  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_input_error && out_month_out == 4'd2) |->
      (out_month_length == (out_leap_year ? 5'd29 : 5'd28)))
    else $error("february length disagrees with leap flag");

endmodule

bind civil_date_day_converter_top cddc_checker u_cddc_checker (.*);
